@@ hw/rtl/pcmb_pkg.sv @@
// Shared types and constants for the palette colour math and brightness block.
`timescale 1ns / 1ps
`default_nettype none

package pcmb_pkg;

    // Channel and word widths
    localparam int unsigned CH_W      = 5;
    localparam int unsigned COLOUR_W  = 3 * CH_W;
    localparam int unsigned OUT_W     = 8;
    localparam int unsigned BRIGHT_W  = 4;
    localparam int unsigned PROD_W    = OUT_W + BRIGHT_W;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned LAT       = 3;

    // Channel clamp ceiling and source limit for math
    localparam logic [CH_W:0] CH_MAX       = 6'd31;
    localparam logic [2:0]    SOURCE_LIMIT = 3'd6;

    // math_control bit positions
    localparam int unsigned HALVE_POS    = 6;
    localparam int unsigned SUBTRACT_POS = 7;

    // Divide by 15: q = ((x + 1) * 4369) >> 16, exact for x below 65535
    localparam int unsigned         RECIP_W      = 13;
    localparam logic [RECIP_W-1:0]  DIV15_RECIP  = 13'd4369;
    localparam int unsigned         DIV15_SHIFT  = 16;
    localparam int unsigned         QPROD_W      = PROD_W + RECIP_W;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_BRIGHTNESS    = 3'd0;
    localparam logic [2:0] REG_SCREEN_BLANK  = 3'd1;
    localparam logic [2:0] REG_MATH_CONTROL  = 3'd2;
    localparam logic [2:0] REG_SUB_SELECT    = 3'd3;
    localparam logic [2:0] REG_FIXED_COLOUR  = 3'd4;

    // Reset value of master brightness
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 4'd15;

    // Per-pixel control shared by the three channel slices
    typedef struct packed {
        logic                apply;
        logic                subtract;
        logic                halve;
        logic                blank;
        logic [BRIGHT_W-1:0] brightness;
    } t_ch_ctrl;

endpackage

`default_nettype wire

@@ hw/rtl/pcmb_channel.sv @@
// One color channel: add/subtract, halve, clamp, expand and brightness scale.
`timescale 1ns / 1ps
`default_nettype none

module pcmb_channel (
    input  wire logic                          i_clk,
    input  wire logic [pcmb_pkg::CH_W-1:0]     i_main,
    input  wire logic [pcmb_pkg::CH_W-1:0]     i_second,
    input  wire pcmb_pkg::t_ch_ctrl            i_ctrl,
    output logic      [pcmb_pkg::OUT_W-1:0]    o_chan
);

    logic [pcmb_pkg::CH_W:0]      n_sum;
    logic [pcmb_pkg::CH_W:0]      n_half;
    logic [pcmb_pkg::CH_W-1:0]    n_clamp;
    logic [pcmb_pkg::OUT_W-1:0]   n_expand;
    logic [pcmb_pkg::PROD_W-1:0]  n_prod;
    logic [pcmb_pkg::PROD_W-1:0]  r_prod;
    logic [pcmb_pkg::QPROD_W-1:0] n_qprod;
    logic [pcmb_pkg::OUT_W-1:0]   r_chan;

    // Color math, halve, clamp to 31, expand to 8 bits, scale by brightness
    always_comb begin
        n_sum = {1'b0, i_main};
        if (i_ctrl.apply) begin
            if (i_ctrl.subtract) begin
                n_sum = (i_main >= i_second) ? {1'b0, i_main - i_second}
                                             : '0;
            end else begin
                n_sum = {1'b0, i_main} + {1'b0, i_second};
            end
        end
        n_half   = i_ctrl.halve ? (n_sum >> 1) : n_sum;
        n_clamp  = (n_half > pcmb_pkg::CH_MAX) ? pcmb_pkg::CH_MAX[pcmb_pkg::CH_W-1:0]
                                               : n_half[pcmb_pkg::CH_W-1:0];
        n_expand = {n_clamp, n_clamp[pcmb_pkg::CH_W-1 -: 3]};
        n_prod   = i_ctrl.blank ? '0
                 : pcmb_pkg::PROD_W'(n_expand) * pcmb_pkg::PROD_W'(i_ctrl.brightness);
    end

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Divide by 15 through the reciprocal
    assign n_qprod = (pcmb_pkg::QPROD_W'(r_prod) + pcmb_pkg::QPROD_W'(1))
                   * pcmb_pkg::QPROD_W'(pcmb_pkg::DIV15_RECIP);

    always_ff @(posedge i_clk) begin
        r_chan <= n_qprod[pcmb_pkg::DIV15_SHIFT +: pcmb_pkg::OUT_W];
    end

    assign o_chan = r_chan;

endmodule

`default_nettype wire

@@ hw/rtl/palette_colour_math_brightness.sv @@
// Top level: pixel color math and master brightness with APB register port.
//
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+-------------------------
//  pixel in | i_main_color .. i_sub_present           | start && !busy
//  pixel out| o_red_out, o_green_out, o_blue_out      | o_valid strobe, 1 cycle
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// One pixel is taken every cycle; busy stays low. A pixel's result passes the
// input register, the channel math and brightness product register and the
// divide-by-15 register before it strobes out. Reset clears the valid pipe and
// the registers to their defaults. The receiver cannot stall, so nothing holds back.
`timescale 1ns / 1ps
`default_nettype none

module palette_colour_math_brightness (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // pixel input
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [pcmb_pkg::COLOUR_W-1:0]     i_main_color,
    input  wire logic                              i_main_rgb_enable,
    input  wire logic                              i_math_window,
    input  wire logic [2:0]                        i_source_layer,
    input  wire logic [pcmb_pkg::COLOUR_W-1:0]     i_sub_colour,
    input  wire logic                              i_sub_present,
    // pixel output
    output logic                                   o_valid,
    output logic      [pcmb_pkg::OUT_W-1:0]        o_red_out,
    output logic      [pcmb_pkg::OUT_W-1:0]        o_green_out,
    output logic      [pcmb_pkg::OUT_W-1:0]        o_blue_out,
    // register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pcmb_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [pcmb_pkg::DATA_W-1:0]       pwdata,
    output logic      [pcmb_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready
);

    localparam int unsigned CW = pcmb_pkg::CH_W;

    // Configuration registers
    logic [pcmb_pkg::BRIGHT_W-1:0] r_brightness;
    logic                          r_screen_blank;
    logic [7:0]                    r_math_control;
    logic                          r_sub_select;
    logic [pcmb_pkg::COLOUR_W-1:0] r_fixed_colour;

    // Input register
    logic [pcmb_pkg::COLOUR_W-1:0] r_main_color;
    logic                          r_main_rgb_enable;
    logic                          r_math_window;
    logic [2:0]                    r_source_layer;
    logic [pcmb_pkg::COLOUR_W-1:0] r_sub_colour;
    logic                          r_sub_present;

    logic [pcmb_pkg::LAT-1:0]      r_vld;

    logic                          n_accept;
    logic                          n_wr;
    logic [2:0]                    n_reg_idx;
    logic                          n_use_sub;
    logic                          n_want_half;
    logic [pcmb_pkg::COLOUR_W-1:0] n_main;
    logic [pcmb_pkg::COLOUR_W-1:0] n_second;
    pcmb_pkg::t_ch_ctrl            n_ctrl;

    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign n_accept  = start && !busy;
    assign n_wr      = psel && penable && pwrite && pready;
    assign n_reg_idx = paddr[pcmb_pkg::ADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness    <= pcmb_pkg::BRIGHT_FULL;
            r_screen_blank  <= 1'b0;
            r_math_control  <= '0;
            r_sub_select    <= 1'b0;
            r_fixed_colour  <= '0;
        end else if (n_wr) begin
            unique case (n_reg_idx)
                pcmb_pkg::REG_BRIGHTNESS:    r_brightness    <= pwdata[pcmb_pkg::BRIGHT_W-1:0];
                pcmb_pkg::REG_SCREEN_BLANK:  r_screen_blank  <= pwdata[0];
                pcmb_pkg::REG_MATH_CONTROL:  r_math_control  <= pwdata[7:0];
                pcmb_pkg::REG_SUB_SELECT:    r_sub_select    <= pwdata[0];
                pcmb_pkg::REG_FIXED_COLOUR:  r_fixed_colour  <= pwdata[pcmb_pkg::COLOUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        unique case (n_reg_idx)
            pcmb_pkg::REG_BRIGHTNESS:    prdata = pcmb_pkg::DATA_W'(r_brightness);
            pcmb_pkg::REG_SCREEN_BLANK:  prdata = pcmb_pkg::DATA_W'(r_screen_blank);
            pcmb_pkg::REG_MATH_CONTROL:  prdata = pcmb_pkg::DATA_W'(r_math_control);
            pcmb_pkg::REG_SUB_SELECT:    prdata = pcmb_pkg::DATA_W'(r_sub_select);
            pcmb_pkg::REG_FIXED_COLOUR:  prdata = pcmb_pkg::DATA_W'(r_fixed_colour);
            default:                     prdata = '0;
        endcase
    end

    // Input register, loaded on each beat
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_main_color      <= i_main_color;
            r_main_rgb_enable <= i_main_rgb_enable;
            r_math_window     <= i_math_window;
            r_source_layer    <= i_source_layer;
            r_sub_colour      <= i_sub_colour;
            r_sub_present     <= i_sub_present;
        end
    end

    // Valid pipe, one bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[pcmb_pkg::LAT-2:0], n_accept};
        end
    end

    // Operand select and per-pixel control
    always_comb begin
        n_use_sub   = r_sub_select && r_sub_present;
        n_want_half = r_math_control[pcmb_pkg::HALVE_POS];
        n_main      = r_main_rgb_enable ? r_main_color : '0;
        n_second    = n_use_sub ? r_sub_colour : r_fixed_colour;

        n_ctrl.apply      = r_math_window && (r_source_layer < pcmb_pkg::SOURCE_LIMIT)
                         && r_math_control[r_source_layer];
        n_ctrl.subtract   = r_math_control[pcmb_pkg::SUBTRACT_POS];
        // fixed-color fallback under add-subscreen skips the halve
        n_ctrl.halve      = n_ctrl.apply && n_want_half
                         && (n_use_sub || !r_sub_select);
        n_ctrl.blank      = r_screen_blank;
        n_ctrl.brightness = r_brightness;
    end

    pcmb_channel u_red (
        .i_clk    (i_clk),
        .i_main   (n_main[0 +: CW]),
        .i_second (n_second[0 +: CW]),
        .i_ctrl   (n_ctrl),
        .o_chan   (o_red_out)
    );

    pcmb_channel u_green (
        .i_clk    (i_clk),
        .i_main   (n_main[CW +: CW]),
        .i_second (n_second[CW +: CW]),
        .i_ctrl   (n_ctrl),
        .o_chan   (o_green_out)
    );

    pcmb_channel u_blue (
        .i_clk    (i_clk),
        .i_main   (n_main[2*CW +: CW]),
        .i_second (n_second[2*CW +: CW]),
        .i_ctrl   (n_ctrl),
        .o_chan   (o_blue_out)
    );

    assign o_valid = r_vld[pcmb_pkg::LAT-1];

endmodule

`default_nettype wire

@@ tb/palette_colour_math_brightness_tb.sv @@
// Self-checking testbench for the pixel color math and master brightness block.
`timescale 1ns / 1ps

module palette_colour_math_brightness_tb;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned RAND_PHASES = 10;
    localparam int unsigned PHASE_PIX   = 93;

    // One pixel beat as presented on the input ports
    typedef struct packed {
        logic [pcmb_pkg::COLOUR_W-1:0] main_color;
        logic                          main_rgb_enable;
        logic                          math_window;
        logic [2:0]                    source_layer;
        logic [pcmb_pkg::COLOUR_W-1:0] sub_colour;
        logic                          sub_present;
    } t_pixel;

    // Final 8-bit-per-channel color
    typedef struct packed {
        logic [pcmb_pkg::OUT_W-1:0] red;
        logic [pcmb_pkg::OUT_W-1:0] green;
        logic [pcmb_pkg::OUT_W-1:0] blue;
    } t_rgb888;

    // Register file shadow
    typedef struct packed {
        logic [pcmb_pkg::BRIGHT_W-1:0] brightness;
        logic                          screen_blank;
        logic [7:0]                    math_control;
        logic                          sub_select;
        logic [pcmb_pkg::COLOUR_W-1:0] fixed_colour;
    } t_regs;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [pcmb_pkg::COLOUR_W-1:0] i_main_color = '0;
    logic                          i_main_rgb_enable = 1'b0;
    logic                          i_math_window = 1'b0;
    logic [2:0]                    i_source_layer = '0;
    logic [pcmb_pkg::COLOUR_W-1:0] i_sub_colour = '0;
    logic                          i_sub_present = 1'b0;
    logic                          o_valid;
    logic [pcmb_pkg::OUT_W-1:0]    o_red_out;
    logic [pcmb_pkg::OUT_W-1:0]    o_green_out;
    logic [pcmb_pkg::OUT_W-1:0]    o_blue_out;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [pcmb_pkg::ADDR_W-1:0]   paddr = '0;
    logic [pcmb_pkg::DATA_W-1:0]   pwdata = '0;
    logic [pcmb_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    t_pixel  pix_pending[$];
    t_rgb888 pix_expected[$];
    t_regs   cfg;
    int      n_fail = 0;
    int      idle_left = 0;
    bit      no_idle = 1'b0;
    int      quiet_cycles = 0;

    palette_colour_math_brightness u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_main_color      (i_main_color),
        .i_main_rgb_enable (i_main_rgb_enable),
        .i_math_window     (i_math_window),
        .i_source_layer    (i_source_layer),
        .i_sub_colour      (i_sub_colour),
        .i_sub_present     (i_sub_present),
        .o_valid           (o_valid),
        .o_red_out         (o_red_out),
        .o_green_out       (o_green_out),
        .o_blue_out        (o_blue_out),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 125 MHz clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_pixel mk_pix(input logic [pcmb_pkg::COLOUR_W-1:0] main_c,
                                      input logic rgb_en,
                                      input logic window, input logic [2:0] src,
                                      input logic [pcmb_pkg::COLOUR_W-1:0] sub_c,
                                      input logic sub_ok);
        t_pixel p;
        p.main_color      = main_c;
        p.main_rgb_enable = rgb_en;
        p.math_window     = window;
        p.source_layer    = src;
        p.sub_colour      = sub_c;
        p.sub_present     = sub_ok;
        return p;
    endfunction

    function automatic t_regs mk_regs(input logic [pcmb_pkg::BRIGHT_W-1:0] br,
                                      input logic blank,
                                      input logic [7:0] mc, input logic add_sub,
                                      input logic [pcmb_pkg::COLOUR_W-1:0] fixed_c);
        t_regs r;
        r.brightness    = br;
        r.screen_blank  = blank;
        r.math_control  = mc;
        r.sub_select    = add_sub;
        r.fixed_colour  = fixed_c;
        return r;
    endfunction

    // Register value as seen on the data bus
    function automatic logic [pcmb_pkg::DATA_W-1:0] reg_word(input t_regs r,
                                                            input logic [2:0] idx);
        case (idx)
            pcmb_pkg::REG_BRIGHTNESS:   return pcmb_pkg::DATA_W'(r.brightness);
            pcmb_pkg::REG_SCREEN_BLANK: return pcmb_pkg::DATA_W'(r.screen_blank);
            pcmb_pkg::REG_MATH_CONTROL: return pcmb_pkg::DATA_W'(r.math_control);
            pcmb_pkg::REG_SUB_SELECT:   return pcmb_pkg::DATA_W'(r.sub_select);
            default:                    return pcmb_pkg::DATA_W'(r.fixed_colour);
        endcase
    endfunction

    // Halve, clamp, widen to 8 bits, scale by brightness/15
    function automatic logic [pcmb_pkg::OUT_W-1:0] scale_channel(
            input int unsigned c, input bit halve,
            input logic [pcmb_pkg::BRIGHT_W-1:0] br);
        int unsigned wide;
        if (halve)
            c = c >> 1;
        if (c > pcmb_pkg::CH_MAX)
            c = pcmb_pkg::CH_MAX;
        wide = (c << 3) | (c >> 2);
        return pcmb_pkg::OUT_W'((wide * br) / pcmb_pkg::BRIGHT_FULL);
    endfunction

    // Expected output color for one pixel under register set r
    function automatic t_rgb888 predict_pixel(input t_pixel p, input t_regs r);
        t_rgb888       res;
        int unsigned   ch_r, ch_g, ch_b, op_r, op_g, op_b;
        logic [pcmb_pkg::COLOUR_W-1:0] second;
        bit            halve, want_half;
        res = '0;
        ch_r = 0;
        ch_g = 0;
        ch_b = 0;
        halve = 1'b0;
        if (r.screen_blank)
            return res;
        if (p.main_rgb_enable) begin
            ch_r = p.main_color[4:0];
            ch_g = p.main_color[9:5];
            ch_b = p.main_color[14:10];
        end
        if (p.math_window && p.source_layer < pcmb_pkg::SOURCE_LIMIT &&
            r.math_control[p.source_layer]) begin
            want_half = r.math_control[pcmb_pkg::HALVE_POS];
            if (r.sub_select && p.sub_present) begin
                second = p.sub_colour;
                halve  = want_half;
            end else begin
                // fixed color; no halving when it stands in for the subscreen
                second = r.fixed_colour;
                halve  = !r.sub_select && want_half;
            end
            op_r = second[4:0];
            op_g = second[9:5];
            op_b = second[14:10];
            if (r.math_control[pcmb_pkg::SUBTRACT_POS]) begin
                ch_r = (ch_r >= op_r) ? ch_r - op_r : 0;
                ch_g = (ch_g >= op_g) ? ch_g - op_g : 0;
                ch_b = (ch_b >= op_b) ? ch_b - op_b : 0;
            end else begin
                ch_r += op_r;
                ch_g += op_g;
                ch_b += op_b;
            end
        end
        res.red   = scale_channel(ch_r, halve, r.brightness);
        res.green = scale_channel(ch_g, halve, r.brightness);
        res.blue  = scale_channel(ch_b, halve, r.brightness);
        return res;
    endfunction

    task automatic check_value(input string what, input logic [pcmb_pkg::DATA_W-1:0] exp_v,
                               input logic [pcmb_pkg::DATA_W-1:0] act_v);
        if (act_v !== exp_v) begin
            n_fail++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endtask

    // Colors biased toward the channel extremes
    function automatic logic [pcmb_pkg::COLOUR_W-1:0] rand_colour();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom_range(0, 1) ? 5'd31 : 5'd0, $urandom_range(0, 1) ? 5'd31 : 5'd0,
                       $urandom_range(0, 1) ? 5'd31 : 5'd0};
            default: return pcmb_pkg::COLOUR_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        return mk_pix(rand_colour(), $urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0,
                      3'($urandom_range(0, 7)), rand_colour(), 1'($urandom_range(0, 1)));
    endfunction

    // Register set for random phase k; early phases pin the extremes
    function automatic t_regs rand_regs(input int k);
        t_regs r;
        r.brightness    = (k == 0) ? 4'd0 : (k == 1) ? 4'd15 : 4'($urandom_range(0, 15));
        r.screen_blank  = (k == 6);
        r.math_control  = (k == 2) ? 8'hFF : (k == 3) ? 8'h00 :
                          ($urandom_range(0, 1) ? 8'($urandom) | 8'h3F : 8'($urandom));
        r.sub_select    = k[0];
        r.fixed_colour  = (k == 4) ? 15'h7FFF : (k == 5) ? 15'h0000 : rand_colour();
        return r;
    endfunction

    // APB write: setup then access, done when pready is seen high
    task automatic reg_write(input logic [2:0] idx, input logic [pcmb_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // APB read, data checked at the completing edge
    task automatic reg_read_check(input logic [2:0] idx,
                                  input logic [pcmb_pkg::DATA_W-1:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_value($sformatf("register %0d read", idx), want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back_all();
        logic [2:0] idx;
        for (int i = pcmb_pkg::REG_BRIGHTNESS; i <= pcmb_pkg::REG_FIXED_COLOUR; i++) begin
            idx = 3'(i);
            reg_read_check(idx, reg_word(cfg, idx));
        end
    endtask

    task automatic load_config(input t_regs r);
        logic [2:0] idx;
        for (int i = pcmb_pkg::REG_BRIGHTNESS; i <= pcmb_pkg::REG_FIXED_COLOUR; i++) begin
            idx = 3'(i);
            reg_write(idx, reg_word(r, idx));
        end
        cfg = r;
        read_back_all();
    endtask

    // Wait until every queued beat is taken and every result is back
    task automatic drain();
        do @(negedge i_clk);
        while (pix_pending.size() != 0 || start || pix_expected.size() != 0);
        repeat (pcmb_pkg::LAT + 1) @(negedge i_clk);
    endtask

    // Driver: feeds pending pixels, with random idle bursts
    always @(posedge i_clk) begin : pixel_driver
        t_pixel nxt;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left = 0;
        end else begin
            // accepted beat: queue its expected color
            if (start && !busy)
                pix_expected.push_back(predict_pixel(
                    mk_pix(i_main_color, i_main_rgb_enable, i_math_window, i_source_layer,
                           i_sub_colour, i_sub_present), cfg));
            if (start && busy) begin
                // beat not taken yet: hold it
            end else if (idle_left != 0) begin
                idle_left = idle_left - 1;
                start     <= 1'b0;
            end else if (pix_pending.size() != 0 && !no_idle && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(0, 15);
                start     <= 1'b0;
            end else if (pix_pending.size() != 0) begin
                nxt = pix_pending.pop_front();
                i_main_color      <= nxt.main_color;
                i_main_rgb_enable <= nxt.main_rgb_enable;
                i_math_window     <= nxt.math_window;
                i_source_layer    <= nxt.source_layer;
                i_sub_colour      <= nxt.sub_colour;
                i_sub_present     <= nxt.sub_present;
                start             <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : pixel_monitor
        t_rgb888 want;
        if (i_rst_n && o_valid) begin
            if (pix_expected.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result beat: expected none, got %0d %0d %0d",
                         $time, o_red_out, o_green_out, o_blue_out);
            end else begin
                want = pix_expected.pop_front();
                check_value("red_out", pcmb_pkg::DATA_W'(want.red),
                            pcmb_pkg::DATA_W'(o_red_out));
                check_value("green_out", pcmb_pkg::DATA_W'(want.green),
                            pcmb_pkg::DATA_W'(o_green_out));
                check_value("blue_out", pcmb_pkg::DATA_W'(want.blue),
                            pcmb_pkg::DATA_W'(o_blue_out));
            end
        end
    end

    // Watchdog: too long without any beat, result or register transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("** palette_colour_math_brightness: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        cfg = mk_regs(pcmb_pkg::BRIGHT_FULL, 1'b0, 8'h00, 1'b0, 15'h0000);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, no math: extremes and main color disabled
        read_back_all();
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd0, 15'h7FFF, 1'b1));
        pix_pending.push_back(mk_pix(15'h0000, 1'b1, 1'b1, 3'd0, 15'h0000, 1'b0));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b0, 1'b0, 3'd5, 15'h7FFF, 1'b1));
        pix_pending.push_back(mk_pix(15'h5555, 1'b1, 1'b1, 3'd7, 15'h2AAA, 1'b1));
        drain();

        // subtract + halve on subscreen; fixed fallback skips halving;
        // source six and a closed window pass main through
        load_config(mk_regs(4'd15, 1'b0, 8'hFF, 1'b1, 15'h7FFF));
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd0, 15'h7FFF, 1'b1));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd1, 15'h0421, 1'b0));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd5, 15'h0421, 1'b1));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd6, 15'h0421, 1'b1));
        pix_pending.push_back(mk_pix(15'h1234, 1'b1, 1'b0, 3'd2, 15'h0421, 1'b1));
        drain();

        // plain add of fixed color, clamp at 31, mid brightness
        load_config(mk_regs(4'd7, 1'b0, 8'h3F, 1'b0, 15'h7FFF));
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd5, 15'h0000, 1'b1));
        pix_pending.push_back(mk_pix(15'h4210, 1'b1, 1'b1, 3'd3, 15'h7FFF, 1'b0));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd7, 15'h7FFF, 1'b1));
        drain();

        // halving with fixed color when add-subscreen is off; source not enabled
        load_config(mk_regs(4'd15, 1'b0, 8'h41, 1'b0, 15'h1234));
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd0, 15'h0000, 1'b1));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd1, 15'h0000, 1'b1));
        drain();

        // subtract with floor at zero
        load_config(mk_regs(4'd15, 1'b0, 8'hC2, 1'b1, 15'h0000));
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h0421, 1'b1, 1'b1, 3'd1, 15'h7FFF, 1'b1));
        pix_pending.push_back(mk_pix(15'h7C00, 1'b1, 1'b1, 3'd1, 15'h03FF, 1'b1));
        drain();

        // forced blank
        load_config(mk_regs(4'd15, 1'b1, 8'hFF, 1'b1, 15'h7FFF));
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd0, 15'h7FFF, 1'b1));
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b0, 3'd7, 15'h0000, 1'b0));
        drain();

        // brightness zero
        load_config(mk_regs(4'd0, 1'b0, 8'h00, 1'b0, 15'h0000));
        @(negedge i_clk);
        pix_pending.push_back(mk_pix(15'h7FFF, 1'b1, 1'b1, 3'd0, 15'h7FFF, 1'b1));
        pix_pending.push_back(mk_pix(15'h5555, 1'b1, 1'b0, 3'd6, 15'h0000, 1'b0));
        drain();

        // random phases, each under its own register set
        for (int k = 0; k < RAND_PHASES; k++) begin
            load_config(rand_regs(k));
            @(negedge i_clk);
            if (k == RAND_PHASES - 1)
                no_idle = 1'b1;
            repeat (PHASE_PIX) pix_pending.push_back(rand_pixel());
            drain();
        end

        if (n_fail == 0) begin
            $display("** palette_colour_math_brightness: PASSED **");
        end else begin
            $display("** palette_colour_math_brightness: FAILED **");
        end
        $finish;
    end

endmodule

@@ palette_colour_math_brightness.f @@
hw/rtl/pcmb_pkg.sv
hw/rtl/pcmb_channel.sv
hw/rtl/palette_colour_math_brightness.sv
tb/palette_colour_math_brightness_tb.sv
